FILE: rtl/px2ba_pkg.sv
// Shared constants for the 2x2 block-average pixelation unit.
package px2ba_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam int PIX_W     = 8;
	localparam int PSUM_W    = PIX_W + 1;
	localparam int COORD_W   = 10;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

endpackage

FILE: rtl/px2ba_ram.sv
// Generic simple dual-port RAM with registered read.
module px2ba_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 512
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/pixelate_2x2_block_average_unit.sv
// Top level of the 2x2 block-average pixelation unit.
// Pixels enter in raster order, one per cycle while in_stall is low. Pixels of even rows of
// complete blocks give no result: their pair sums go to a line store RAM of (MAX_WIDTH+1)/2
// entries. The odd-row, odd-column pixel of a block reads its pair sum back and gives four
// results: top-left, bottom-left, top-right, bottom-right, the last one marked. Pixels of an
// incomplete right or bottom block pass through as one result each. Results leave one per
// cycle while out_stall is low, through a four-entry job queue, so the single output port
// sets the rate: even rows at one pixel per cycle, odd rows of complete blocks slower, edge
// pixels at one per cycle. Writing either size register restarts the frame.
module pixelate_2x2_block_average_unit #(
	parameter int MAX_WIDTH  = px2ba_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = px2ba_pkg::DEF_MAX_HEIGHT
) (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [px2ba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [px2ba_pkg::CFG_W-1:0]        cfg_data,

	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [px2ba_pkg::PIX_W-1:0]        pixel_value,

	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [px2ba_pkg::PIX_W-1:0]        out_value,
	output logic [px2ba_pkg::COORD_W-1:0]      out_row,
	output logic [px2ba_pkg::COORD_W-1:0]      out_col,
	output logic                               last_of_run
);

	import px2ba_pkg::*;

	localparam int CW         = ($clog2(MAX_WIDTH) < 2) ? 2 : $clog2(MAX_WIDTH);
	localparam int RW         = $clog2(MAX_HEIGHT);
	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int LAW        = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int SZW_W      = (CFG_W > CW + 1) ? CFG_W : CW + 1;
	localparam int SZH_W      = (CFG_W > RW + 1) ? CFG_W : RW + 1;
	localparam int JOB_DEPTH  = 4;
	localparam int JPW        = $clog2(JOB_DEPTH);

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic [RW-1:0]    row;
		logic [CW-1:0]    col;
		logic             quad;
	} job_t;

	// frame size and position
	logic [CW:0]      width_q;
	logic [RW:0]      height_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [PIX_W-1:0] prev_q;

	logic [SZW_W-1:0] cfg_w_ext;
	logic [SZH_W-1:0] cfg_h_ext;
	logic [CW:0]      cfg_w_clamp;
	logic [RW:0]      cfg_h_clamp;
	logic             cfg_xfer;

	logic             in_xfer;
	logic             complete;
	logic             col_last;
	logic             row_last;

	logic             ram_we;
	logic             ram_re;
	logic [LAW-1:0]   ram_addr;
	logic [PSUM_W-1:0] ram_wdata;
	logic [PSUM_W-1:0] ram_rdata;

	// stage 1
	logic             valid_s1;
	logic             emit_s1;
	logic             quad_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [PIX_W-1:0] prev_s1;
	logic [RW-1:0]    row_s1;
	logic [CW-1:0]    col_s1;
	logic [PSUM_W:0]  sum_s1;
	job_t             job_s1;

	// job queue
	job_t             jobs_q [JOB_DEPTH];
	logic [JPW-1:0]   wr_ptr_q;
	logic [JPW-1:0]   rd_ptr_q;
	logic [JPW:0]     count_q;
	logic [1:0]       sub_q;
	logic             job_full;
	logic             enq;
	logic             deq;
	logic             out_xfer;
	job_t             head;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign cfg_w_ext = SZW_W'(cfg_data);
	assign cfg_h_ext = SZH_W'(cfg_data);

	always_comb begin
		if (cfg_w_ext == '0) begin
			cfg_w_clamp = (CW+1)'(1);
		end else if (cfg_w_ext > SZW_W'(MAX_WIDTH)) begin
			cfg_w_clamp = (CW+1)'(MAX_WIDTH);
		end else begin
			cfg_w_clamp = (CW+1)'(cfg_w_ext);
		end
		if (cfg_h_ext == '0) begin
			cfg_h_clamp = (RW+1)'(1);
		end else if (cfg_h_ext > SZH_W'(MAX_HEIGHT)) begin
			cfg_h_clamp = (RW+1)'(MAX_HEIGHT);
		end else begin
			cfg_h_clamp = (RW+1)'(cfg_h_ext);
		end
	end

	assign job_full = (count_q == (JPW+1)'(JOB_DEPTH));
	assign in_stall = valid_s1 && emit_s1 && job_full;
	assign in_xfer  = in_valid && !in_stall;

	assign complete = ((CW+1)'(col_q | CW'(1)) < width_q) &&
			((RW+1)'(row_q | RW'(1)) < height_q);
	assign col_last = ((CW+1)'(col_q) + (CW+1)'(1)) >= width_q;
	assign row_last = ((RW+1)'(row_q) + (RW+1)'(1)) >= height_q;

	assign ram_addr  = LAW'(col_q >> 1);
	assign ram_we    = in_xfer && complete && !row_q[0] && col_q[0];
	assign ram_re    = in_xfer && complete && row_q[0] && col_q[0];
	assign ram_wdata = PSUM_W'(prev_q) + PSUM_W'(pixel_value);

	px2ba_ram #(
		.WIDTH (PSUM_W),
		.DEPTH (LINE_DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	// size registers, counters, previous pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= (CW+1)'(MAX_WIDTH);
			height_q <= (RW+1)'(MAX_HEIGHT);
			col_q    <= '0;
			row_q    <= '0;
			prev_q   <= '0;
		end else if (cfg_xfer) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: begin
					width_q <= cfg_w_clamp;
					col_q   <= '0;
					row_q   <= '0;
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= cfg_h_clamp;
					col_q    <= '0;
					row_q    <= '0;
				end
				default: begin
				end
			endcase
		end else if (in_xfer) begin
			if (complete && !col_q[0]) begin
				prev_q <= pixel_value;
			end
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// stage 1: hold while its result waits on a full queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
			quad_s1  <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_xfer;
			emit_s1  <= !complete || (row_q[0] && col_q[0]);
			quad_s1  <= complete;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pix_s1  <= pixel_value;
			prev_s1 <= prev_q;
			row_s1  <= row_q;
			col_s1  <= col_q;
		end
	end

	assign sum_s1 = (PSUM_W+1)'(ram_rdata) + (PSUM_W+1)'(prev_s1) + (PSUM_W+1)'(pix_s1);

	always_comb begin
		job_s1.value = quad_s1 ? PIX_W'(sum_s1 >> 2) : pix_s1;
		job_s1.row   = row_s1;
		job_s1.col   = col_s1;
		job_s1.quad  = quad_s1;
	end

	// job queue and quad expansion
	assign head      = jobs_q[rd_ptr_q];
	assign out_valid = (count_q != '0);
	assign out_xfer  = out_valid && !out_stall;
	assign enq       = valid_s1 && emit_s1 && !job_full;
	assign deq       = out_xfer && (!head.quad || (sub_q == 2'd3));

	always_ff @(posedge clk) begin
		if (enq) begin
			jobs_q[wr_ptr_q] <= job_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			sub_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + JPW'(1);
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + JPW'(1);
				sub_q    <= '0;
			end else if (out_xfer) begin
				sub_q <= sub_q + 2'd1;
			end
			if (enq && !deq) begin
				count_q <= count_q + (JPW+1)'(1);
			end else if (deq && !enq) begin
				count_q <= count_q - (JPW+1)'(1);
			end
		end
	end

	always_comb begin
		out_value = head.value;
		if (head.quad) begin
			out_row     = COORD_W'(sub_q[0] ? head.row : head.row - RW'(1));
			out_col     = COORD_W'(sub_q[1] ? head.col : head.col - CW'(1));
			last_of_run = (sub_q == 2'd3);
		end else begin
			out_row     = COORD_W'(head.row);
			out_col     = COORD_W'(head.col);
			last_of_run = 1'b1;
		end
	end

endmodule
